[design/ccdst_pkg.sv]
// Package for the calendar clock: transaction types, state type, constants and month lengths.
package ccdst_pkg;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t        command;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [4:0]  load_hour;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [11:0] load_year;
        logic [2:0]  load_weekday;
    } in_t;

    typedef struct packed
    {
        logic [5:0]  cur_second;
        logic [5:0]  cur_minute;
        logic [4:0]  cur_hour;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [11:0] cur_year;
        logic [2:0]  cur_weekday;
        logic        dst_applied;
        logic        load_error;
    } out_t;

    typedef struct packed
    {
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] year_count;
        logic [2:0]  weekday;
        logic        dst_done;
    } cal_state_t;

    localparam logic [5:0] SEC_MAX     = 6'd59;
    localparam logic [5:0] MIN_MAX     = 6'd59;
    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [4:0] HOUR_DST    = 5'd1;
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] DST_MIN_DAY = 5'd7;
    localparam logic [3:0] MONTH_JAN   = 4'd1;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [3:0] MONTH_MAR   = 4'd3;
    localparam logic [3:0] MONTH_APR   = 4'd4;
    localparam logic [3:0] MONTH_JUN   = 4'd6;
    localparam logic [3:0] MONTH_SEP   = 4'd9;
    localparam logic [3:0] MONTH_NOV   = 4'd11;
    localparam logic [3:0] MONTH_DEC   = 4'd12;
    localparam logic [2:0] WDAY_MON    = 3'd1;
    localparam logic [2:0] WDAY_SUN    = 3'd7;

    localparam cal_state_t RESET_STATE = '{
        seconds:      6'd0,
        minutes:      6'd0,
        hours:        5'd0,
        day_of_month: DAY_FIRST,
        month_number: MONTH_JAN,
        year_count:   12'd0,
        weekday:      WDAY_MON,
        dst_done:     1'b0
    };

    // Days in a month; February is long in every year divisible by four
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [11:0] year);
        logic [4:0] len;
        case (month)
            MONTH_FEB: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[design/ccdst_step.sv]
// Next-state logic of the calendar clock for one tick or load transaction.
module ccdst_step
    import ccdst_pkg::*;
(
    input  cal_state_t cur,
    input  in_t        item,
    output cal_state_t nxt,
    output logic       load_error
);

    cal_state_t tick;
    logic [4:0] load_len;
    logic [4:0] cur_len;
    logic       load_ok;

    // Validate the load fields against calendar ranges
    always_comb
    begin
        load_len = month_length(item.load_month, item.load_year);
        load_ok  = (item.load_second <= SEC_MAX) && (item.load_minute <= MIN_MAX) &&
                   (item.load_hour <= HOUR_MAX) &&
                   (item.load_month >= MONTH_JAN) && (item.load_month <= MONTH_DEC) &&
                   (item.load_day >= DAY_FIRST) && (item.load_day <= load_len) &&
                   (item.load_weekday >= WDAY_MON) && (item.load_weekday <= WDAY_SUN);
    end

    // Advance one second, carrying through the calendar with the daylight-saving shifts
    always_comb
    begin
        tick    = cur;
        cur_len = month_length(cur.month_number, cur.year_count);
        if (cur.seconds < SEC_MAX)
        begin
            tick.seconds = cur.seconds + 6'd1;
        end
        else
        begin
            tick.seconds = 6'd0;
            if (cur.minutes < MIN_MAX)
            begin
                tick.minutes = cur.minutes + 6'd1;
            end
            else
            begin
                tick.minutes = 6'd0;
                if ((cur.hours == HOUR_DST) && (cur.weekday == WDAY_SUN) && !cur.dst_done &&
                    (cur.month_number == MONTH_MAR) && (cur.day_of_month >= DST_MIN_DAY))
                begin
                    // spring forward: skip hour 2
                    tick.hours    = 5'd3;
                    tick.dst_done = 1'b1;
                end
                else if ((cur.hours == HOUR_DST) && (cur.weekday == WDAY_SUN) &&
                         !cur.dst_done && (cur.month_number == MONTH_NOV))
                begin
                    // fall back: repeat hour 1
                    tick.hours    = HOUR_DST;
                    tick.dst_done = 1'b1;
                end
                else if (cur.hours < HOUR_MAX)
                begin
                    tick.hours = cur.hours + 5'd1;
                end
                else
                begin
                    tick.hours   = 5'd0;
                    tick.weekday = (cur.weekday >= WDAY_SUN) ? WDAY_MON
                                                             : cur.weekday + 3'd1;
                    if (cur.day_of_month < cur_len)
                    begin
                        tick.day_of_month = cur.day_of_month + 5'd1;
                    end
                    else
                    begin
                        tick.day_of_month = DAY_FIRST;
                        tick.dst_done     = 1'b0;
                        if (cur.month_number < MONTH_DEC)
                        begin
                            tick.month_number = cur.month_number + 4'd1;
                        end
                        else
                        begin
                            tick.month_number = MONTH_JAN;
                            tick.year_count   = cur.year_count + 12'd1;
                        end
                    end
                end
            end
        end
    end

    // Select the new state by command
    always_comb
    begin
        nxt        = cur;
        load_error = 1'b0;
        case (item.command)
            CMD_TICK:
            begin
                nxt = tick;
            end
            CMD_LOAD:
            begin
                if (load_ok)
                begin
                    nxt.seconds      = item.load_second;
                    nxt.minutes      = item.load_minute;
                    nxt.hours        = item.load_hour;
                    nxt.day_of_month = item.load_day;
                    nxt.month_number = item.load_month;
                    nxt.year_count   = item.load_year;
                    nxt.weekday      = item.load_weekday;
                    nxt.dst_done     = 1'b0;
                end
                else
                begin
                    load_error = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

[design/calendar_clock_with_dst.sv]
// Top level of the calendar clock: input register, step logic, state and result registers.
//
//   channel | signals                     | direction | payload
//   --------+-----------------------------+-----------+---------
//   in      | in_valid, in_ready, in_data | to block  | in_t
//   out     | out_valid, out_ready, out_data | from block | out_t
//
// Each transaction passes through the input register, then through the step logic
// into the state and result registers.
// One transaction is accepted every cycle while the output is not stalled; the state
// is updated as the result is written, so back-to-back items chain correctly.
// Reset puts the clock at 00:00:00, day 1, month 1, year 0, weekday 1.
// A stalled output holds the result and the input register; in_ready drops once
// the input register is also full.
module calendar_clock_with_dst
    import ccdst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic       item_valid_reg;
    in_t        item_reg;
    cal_state_t state_reg;
    cal_state_t state_next;
    logic       res_valid_reg;
    out_t       res_reg;
    logic       err_next;
    logic       advance;

    // Move the held item forward when the result register is free or its result is taken
    assign advance  = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    ccdst_step u_step
    (
        .cur        (state_reg),
        .item       (item_reg),
        .nxt        (state_next),
        .load_error (err_next)
    );

    // Hold the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    // Update the calendar state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RESET_STATE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the result transaction
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.cur_second  <= state_next.seconds;
            res_reg.cur_minute  <= state_next.minutes;
            res_reg.cur_hour    <= state_next.hours;
            res_reg.cur_day     <= state_next.day_of_month;
            res_reg.cur_month   <= state_next.month_number;
            res_reg.cur_year    <= state_next.year_count;
            res_reg.cur_weekday <= state_next.weekday;
            res_reg.dst_applied <= state_next.dst_done;
            res_reg.load_error  <= err_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule
